// ===== src/ihp_pkg.sv =====
`default_nettype none

package ihp_pkg;

   localparam int MAX_HEADER_BYTES = 60;
   localparam int MIN_HEADER_BYTES = 20;
   localparam int COUNT_BITS       = 16;

   localparam logic [3:0]  IP_VERSION   = 4'd4;
   localparam logic [3:0]  MIN_IHL      = 4'd5;
   localparam logic [15:0] SUM_GOOD     = 16'hffff;
   localparam logic [15:0] LEN_MAX      = 16'hffff;
   localparam int          FLAG_RSV_BIT = 15;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TRUNCATED = 2'd1,
      STATUS_MALFORMED = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  hdr_len;
      logic [15:0] body_len;
      logic [7:0]  tos_byte;
      logic [15:0] pkt_len;
      logic [15:0] identification;
      logic [15:0] frag_word;
      logic [7:0]  ttl;
      logic [7:0]  protocol;
      logic [15:0] hdr_cksum;
      logic [31:0] source_address;
      logic [31:0] destination_address;
   } rsp_type;

   // packet record handed from the byte parser to the checker
   typedef struct packed {
      logic [15:0] length;
      logic [7:0]  version_ihl;
      logic [7:0]  tos;
      logic [15:0] total;
      logic [15:0] ident;
      logic [15:0] flags;
      logic [15:0] ttl_proto;
      logic [15:0] cksum;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sum;
   } summary_type;

endpackage

`default_nettype wire

// ===== src/ihp_front.sv =====
`default_nettype none

module ihp_front #(
   parameter int COUNT_BITS = ihp_pkg::COUNT_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_accept,
   input  wire ihp_pkg::req_type     in_data,
   output logic                      push,
   output ihp_pkg::summary_type      summary
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in, cnt_nxt;
   logic [7:0]  version_ihl_ff, version_ihl_in, vi_nxt;
   logic [7:0]  tos_ff, tos_in, tos_nxt;
   logic [15:0] total_ff, total_in, total_nxt;
   logic [15:0] ident_ff, ident_in, ident_nxt;
   logic [15:0] flags_ff, flags_in, flags_nxt;
   logic [15:0] ttl_proto_ff, ttl_proto_in, ttl_proto_nxt;
   logic [15:0] cksum_ff, cksum_in, cksum_nxt;
   logic [31:0] src_ff, src_in, src_nxt;
   logic [31:0] dst_ff, dst_in, dst_nxt;
   logic [15:0] sum_ff, sum_in, sum_nxt;
   logic [7:0]  pending_ff, pending_in, pending_nxt;

   logic [COUNT_BITS-1:0] pos;
   logic [7:0]            b;
   logic [5:0]            hl;
   logic [16:0]           s;
   logic                  clear;

   always_comb begin
      pos = byte_count_ff;
      b   = in_data.data_byte;

      vi_nxt        = version_ihl_ff;
      tos_nxt       = tos_ff;
      total_nxt     = total_ff;
      ident_nxt     = ident_ff;
      flags_nxt     = flags_ff;
      ttl_proto_nxt = ttl_proto_ff;
      cksum_nxt     = cksum_ff;
      src_nxt       = src_ff;
      dst_nxt       = dst_ff;
      sum_nxt       = sum_ff;
      pending_nxt   = pending_ff;

      if (pos == COUNT_BITS'(0)) begin
         vi_nxt = b;
      end else if (pos == COUNT_BITS'(1)) begin
         tos_nxt = b;
      end else if (pos <= COUNT_BITS'(3)) begin
         total_nxt = {total_ff[7:0], b};
      end else if (pos <= COUNT_BITS'(5)) begin
         ident_nxt = {ident_ff[7:0], b};
      end else if (pos <= COUNT_BITS'(7)) begin
         flags_nxt = {flags_ff[7:0], b};
      end else if (pos <= COUNT_BITS'(9)) begin
         ttl_proto_nxt = {ttl_proto_ff[7:0], b};
      end else if (pos <= COUNT_BITS'(11)) begin
         cksum_nxt = {cksum_ff[7:0], b};
      end else if (pos <= COUNT_BITS'(15)) begin
         src_nxt = {src_ff[23:0], b};
      end else if (pos <= COUNT_BITS'(19)) begin
         dst_nxt = {dst_ff[23:0], b};
      end

      hl = {vi_nxt[3:0], 2'b00};
      s  = {1'b0, sum_ff} + {1'b0, pending_ff, b};
      if (pos < COUNT_BITS'(hl)) begin
         if (!pos[0]) begin
            pending_nxt = b;
         end else begin
            sum_nxt = s[15:0] + 16'(s[16]);
         end
      end

      cnt_nxt = (byte_count_ff == CNT_MAX) ? byte_count_ff : byte_count_ff + 1'b1;
   end

   always_comb begin
      push  = in_accept && in_data.last_byte;
      clear = push;

      summary.length      = (cnt_nxt > COUNT_BITS'(ihp_pkg::LEN_MAX)) ?
                            ihp_pkg::LEN_MAX : cnt_nxt[15:0];
      summary.version_ihl = vi_nxt;
      summary.tos         = tos_nxt;
      summary.total       = total_nxt;
      summary.ident       = ident_nxt;
      summary.flags       = flags_nxt;
      summary.ttl_proto   = ttl_proto_nxt;
      summary.cksum       = cksum_nxt;
      summary.src         = src_nxt;
      summary.dst         = dst_nxt;
      summary.sum         = sum_nxt;

      byte_count_in  = byte_count_ff;
      version_ihl_in = version_ihl_ff;
      tos_in         = tos_ff;
      total_in       = total_ff;
      ident_in       = ident_ff;
      flags_in       = flags_ff;
      ttl_proto_in   = ttl_proto_ff;
      cksum_in       = cksum_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      sum_in         = sum_ff;
      pending_in     = pending_ff;

      if (clear) begin
         byte_count_in  = '0;
         version_ihl_in = '0;
         tos_in         = '0;
         total_in       = '0;
         ident_in       = '0;
         flags_in       = '0;
         ttl_proto_in   = '0;
         cksum_in       = '0;
         src_in         = '0;
         dst_in         = '0;
         sum_in         = '0;
         pending_in     = '0;
      end else if (in_accept) begin
         byte_count_in  = cnt_nxt;
         version_ihl_in = vi_nxt;
         tos_in         = tos_nxt;
         total_in       = total_nxt;
         ident_in       = ident_nxt;
         flags_in       = flags_nxt;
         ttl_proto_in   = ttl_proto_nxt;
         cksum_in       = cksum_nxt;
         src_in         = src_nxt;
         dst_in         = dst_nxt;
         sum_in         = sum_nxt;
         pending_in     = pending_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         version_ihl_ff <= '0;
         tos_ff         <= '0;
         total_ff       <= '0;
         ident_ff       <= '0;
         flags_ff       <= '0;
         ttl_proto_ff   <= '0;
         cksum_ff       <= '0;
         src_ff         <= '0;
         dst_ff         <= '0;
         sum_ff         <= '0;
         pending_ff     <= '0;
      end else begin
         byte_count_ff  <= byte_count_in;
         version_ihl_ff <= version_ihl_in;
         tos_ff         <= tos_in;
         total_ff       <= total_in;
         ident_ff       <= ident_in;
         flags_ff       <= flags_in;
         ttl_proto_ff   <= ttl_proto_in;
         cksum_ff       <= cksum_in;
         src_ff         <= src_in;
         dst_ff         <= dst_in;
         sum_ff         <= sum_in;
         pending_ff     <= pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/ihp_queue.sv =====
`default_nettype none

module ihp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ihp_pkg::summary_type push_data,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output ihp_pkg::summary_type      head
);

   ihp_pkg::summary_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head      = entry_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/ihp_back.sv =====
`default_nettype none

module ihp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire ihp_pkg::summary_type head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ihp_pkg::rsp_type          rsp_payload
);

   logic             rsp_valid_ff, rsp_valid_in;
   ihp_pkg::rsp_type rsp_ff, rsp_in;
   ihp_pkg::status_type status;
   logic [5:0]       hl;
   logic [15:0]      hl16;
   logic             load;

   always_comb begin
      hl   = {head.version_ihl[3:0], 2'b00};
      hl16 = 16'(hl);
      if (head.length < 16'(ihp_pkg::MIN_HEADER_BYTES)) begin
         status = ihp_pkg::STATUS_TRUNCATED;
      end else if (head.version_ihl[7:4] != ihp_pkg::IP_VERSION ||
                   head.version_ihl[3:0] < ihp_pkg::MIN_IHL) begin
         status = ihp_pkg::STATUS_MALFORMED;
      end else if (hl16 > 16'(ihp_pkg::MAX_HEADER_BYTES)) begin
         status = ihp_pkg::STATUS_MALFORMED;
      end else if (head.length < hl16) begin
         status = ihp_pkg::STATUS_TRUNCATED;
      end else if (head.flags[ihp_pkg::FLAG_RSV_BIT]) begin
         status = ihp_pkg::STATUS_MALFORMED;
      end else if (head.total < hl16) begin
         status = ihp_pkg::STATUS_MALFORMED;
      end else if (head.length < head.total) begin
         status = ihp_pkg::STATUS_TRUNCATED;
      end else if (head.sum != ihp_pkg::SUM_GOOD) begin
         status = ihp_pkg::STATUS_MALFORMED;
      end else begin
         status = ihp_pkg::STATUS_OK;
      end
   end

   always_comb begin
      pop  = head_valid && (!rsp_valid_ff || !rsp_stall);
      load = pop;

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      rsp_in        = rsp_ff;
      if (load) begin
         rsp_in        = '0;
         rsp_in.status = status;
         if (status == ihp_pkg::STATUS_OK) begin
            rsp_in.hdr_len             = hl;
            rsp_in.body_len            = head.total - hl16;
            rsp_in.tos_byte            = head.tos;
            rsp_in.pkt_len             = head.total;
            rsp_in.identification      = head.ident;
            rsp_in.frag_word           = head.flags;
            rsp_in.ttl                 = head.ttl_proto[15:8];
            rsp_in.protocol            = head.ttl_proto[7:0];
            rsp_in.hdr_cksum           = head.cksum;
            rsp_in.source_address      = head.src;
            rsp_in.destination_address = head.dst;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== src/ipv4_header_parser.sv =====
// IPv4 header parser with header checksum check.
// req channel: one packet byte per transfer, in wire order; last_byte marks
// the final byte of a packet. rsp channel: one result per packet, holding a
// status (ok, truncated, malformed), the header fields and the header and
// payload lengths; on any error all fields except status are zero.
// Throughput: one byte per cycle while req_stall is low, and a packet as short as one
// byte may follow the previous one directly. Each byte is captured in the cycle it
// transfers, and each header byte is added into the ones-complement sum.
// On the last byte's transfer the byte parser registers the packet record into a
// two-entry queue; the checker registers the result from the head of the queue.
// When rsp_stall is held, the result stays on rsp_payload unchanged; the queue
// absorbs two more packets, then req_stall rises until the result is taken.
// Reset (synchronous, active high) clears the byte count, captured fields,
// checksum, queue and the output valid; the block is ready in the next cycle.
`default_nettype none

module ipv4_header_parser #(
   parameter int COUNT_BITS = ihp_pkg::COUNT_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ihp_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ihp_pkg::rsp_type      rsp_payload
);

   ihp_pkg::summary_type summary, head;
   logic push, pop, full, not_empty, in_accept;

   assign req_stall = full;
   assign in_accept = req_valid && !req_stall;

   ihp_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_accept(in_accept),
      .in_data  (req_payload),
      .push     (push),
      .summary  (summary)
   );

   ihp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(summary),
      .pop      (pop),
      .full     (full),
      .not_empty(not_empty),
      .head     (head)
   );

   ihp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

// ===== src/ihp_checker.sv =====
`default_nettype none

module ihp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ihp_pkg::rsp_type rsp_payload
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result valid or input stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == ihp_pkg::STATUS_OK ||
                     rsp_payload.status == ihp_pkg::STATUS_TRUNCATED ||
                     rsp_payload.status == ihp_pkg::STATUS_MALFORMED))
      else $error("bad status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ihp_pkg::STATUS_OK |->
         rsp_payload.hdr_len == '0 && rsp_payload.body_len == '0 &&
         rsp_payload.pkt_len == '0 && rsp_payload.source_address == '0 &&
         rsp_payload.destination_address == '0)
      else $error("error result carries fields");

   a_ok_lengths: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ihp_pkg::STATUS_OK |->
         rsp_payload.hdr_len >= 6'(ihp_pkg::MIN_HEADER_BYTES) &&
         rsp_payload.pkt_len >= 16'(rsp_payload.hdr_len) &&
         rsp_payload.body_len ==
            rsp_payload.pkt_len - 16'(rsp_payload.hdr_len))
      else $error("inconsistent lengths on ok result");

endmodule

bind ipv4_header_parser ihp_checker u_ihp_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_ipv4_header_parser.sv =====
module tb_ipv4_header_parser;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STUCK_LIMIT  = 5000;
   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_BYTES = 800;
   localparam int MIN_PACKETS  = 20;
   localparam int QUIET_BYTES  = 250;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {
      DEFECT_VERSION,
      DEFECT_IHL,
      DEFECT_RSV_FLAG,
      DEFECT_TOTAL,
      DEFECT_CHECKSUM,
      DEFECT_CUT,
      DEFECT_NOISE
   } defect_type;

   class ipv4_result_scoreboard;
      bit [15:0] byte_cnt;
      bit [7:0]  ver_ihl, tos, hi_byte;
      bit [15:0] total, ident, flags, ttl_proto, cksum, hdr_sum;
      bit [31:0] src, dst;
      ihp_pkg::rsp_type expected_q[$];
      int        errors, ok_seen, trunc_seen, malformed_seen;

      function new();
         restart();
      endfunction

      function void restart();
         byte_cnt  = '0;
         ver_ihl   = '0;
         tos       = '0;
         hi_byte   = '0;
         total     = '0;
         ident     = '0;
         flags     = '0;
         ttl_proto = '0;
         cksum     = '0;
         hdr_sum   = '0;
         src       = '0;
         dst       = '0;
      endfunction

      // mirror one accepted byte; on the last byte queue the predicted result
      function void note_byte(ihp_pkg::req_type r);
         int                  pos, hl, len;
         bit [7:0]            b;
         bit [16:0]           s;
         ihp_pkg::rsp_type    want;
         ihp_pkg::status_type st;
         b   = r.data_byte;
         pos = byte_cnt;
         hl  = 4 * int'(pos == 0 ? b[3:0] : ver_ihl[3:0]);
         if (pos == 0) ver_ihl = b;
         else if (pos == 1) tos = b;
         else if (pos <= 3) total = {total[7:0], b};
         else if (pos <= 5) ident = {ident[7:0], b};
         else if (pos <= 7) flags = {flags[7:0], b};
         else if (pos <= 9) ttl_proto = {ttl_proto[7:0], b};
         else if (pos <= 11) cksum = {cksum[7:0], b};
         else if (pos <= 15) src = {src[23:0], b};
         else if (pos <= 19) dst = {dst[23:0], b};
         if (pos < hl) begin
            if (pos % 2 == 0) begin
               hi_byte = b;
            end else begin
               s       = hdr_sum + {hi_byte, b};
               hdr_sum = s[15:0] + 16'(s[16]);
            end
         end
         if (byte_cnt != ihp_pkg::LEN_MAX) byte_cnt++;
         if (!r.last_byte) return;

         len = byte_cnt;
         hl  = 4 * int'(ver_ihl[3:0]);
         if (len < ihp_pkg::MIN_HEADER_BYTES) st = ihp_pkg::STATUS_TRUNCATED;
         else if (ver_ihl[7:4] != ihp_pkg::IP_VERSION ||
                  ver_ihl[3:0] < ihp_pkg::MIN_IHL) st = ihp_pkg::STATUS_MALFORMED;
         else if (hl > ihp_pkg::MAX_HEADER_BYTES) st = ihp_pkg::STATUS_MALFORMED;
         else if (len < hl) st = ihp_pkg::STATUS_TRUNCATED;
         else if (flags[ihp_pkg::FLAG_RSV_BIT]) st = ihp_pkg::STATUS_MALFORMED;
         else if (int'(total) < hl) st = ihp_pkg::STATUS_MALFORMED;
         else if (len < int'(total)) st = ihp_pkg::STATUS_TRUNCATED;
         else if (hdr_sum != ihp_pkg::SUM_GOOD) st = ihp_pkg::STATUS_MALFORMED;
         else st = ihp_pkg::STATUS_OK;

         want        = '0;
         want.status = st;
         if (st == ihp_pkg::STATUS_OK) begin
            want.hdr_len             = 6'(hl);
            want.body_len            = total - 16'(hl);
            want.tos_byte            = tos;
            want.pkt_len             = total;
            want.identification      = ident;
            want.frag_word           = flags;
            want.ttl                 = ttl_proto[15:8];
            want.protocol            = ttl_proto[7:0];
            want.hdr_cksum           = cksum;
            want.source_address      = src;
            want.destination_address = dst;
         end
         expected_q.push_back(want);
         restart();
      endfunction

      task report(string field, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("MISMATCH at %0t: %s got 0x%0h, want 0x%0h", $time, field, got, want);
      endtask

      task check_result(ihp_pkg::rsp_type got);
         ihp_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            report("result with no packet pending, status", got.status, '0);
            return;
         end
         want = expected_q.pop_front();
         if (want.status == ihp_pkg::STATUS_OK) ok_seen++;
         else if (want.status == ihp_pkg::STATUS_TRUNCATED) trunc_seen++;
         else malformed_seen++;
         if (got.status !== want.status)
            report("status", got.status, want.status);
         if (got.hdr_len !== want.hdr_len)
            report("hdr_len", got.hdr_len, want.hdr_len);
         if (got.body_len !== want.body_len)
            report("body_len", got.body_len, want.body_len);
         if (got.tos_byte !== want.tos_byte)
            report("tos_byte", got.tos_byte, want.tos_byte);
         if (got.pkt_len !== want.pkt_len)
            report("pkt_len", got.pkt_len, want.pkt_len);
         if (got.identification !== want.identification)
            report("identification", got.identification, want.identification);
         if (got.frag_word !== want.frag_word)
            report("frag_word", got.frag_word, want.frag_word);
         if (got.ttl !== want.ttl)
            report("ttl", got.ttl, want.ttl);
         if (got.protocol !== want.protocol)
            report("protocol", got.protocol, want.protocol);
         if (got.hdr_cksum !== want.hdr_cksum)
            report("hdr_cksum", got.hdr_cksum, want.hdr_cksum);
         if (got.source_address !== want.source_address)
            report("source_address", got.source_address, want.source_address);
         if (got.destination_address !== want.destination_address)
            report("destination_address", got.destination_address,
                   want.destination_address);
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid, req_stall;
   ihp_pkg::req_type req_payload;
   logic             rsp_valid, rsp_stall;
   ihp_pkg::rsp_type rsp_payload;

   ipv4_result_scoreboard sb = new();
   bit [7:0] pkt[$];
   bit       idling = 1'b1;
   bit       hold_req = 1'b0;
   int       stuck_cycles = 0;
   int       bytes_sent = 0;
   int       packets_sent = 0;

   ipv4_header_parser u_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_payload,
      .rsp_valid,
      .rsp_stall,
      .rsp_payload
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) sb.note_byte(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
         else stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("Timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: short random stalls while idling is set, plus one long hold on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // well-formed packet with a correct header checksum; fill < 0 means random bytes
   function automatic void make_packet(int ihl, int total, int extra, int fill);
      int        i;
      bit [15:0] acc;
      bit [16:0] s;
      pkt.delete();
      for (i = 0; i < total + extra; i++)
         pkt.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
      pkt[0]  = {ihp_pkg::IP_VERSION, 4'(ihl)};
      pkt[2]  = 8'(total >> 8);
      pkt[3]  = 8'(total);
      pkt[6]  = pkt[6] & 8'h7f;
      pkt[10] = 8'h00;
      pkt[11] = 8'h00;
      acc = '0;
      for (i = 0; i < 4 * ihl; i += 2) begin
         s   = acc + {pkt[i], pkt[i + 1]};
         acc = s[15:0] + 16'(s[16]);
      end
      pkt[10] = ~acc[15:8];
      pkt[11] = ~acc[7:0];
   endfunction

   function automatic void spoil(defect_type d);
      int v, hl, idx, n, cut;
      hl = 4 * int'(pkt[0][3:0]);
      case (d)
         DEFECT_VERSION: begin
            v = $urandom_range(0, 14);
            if (v >= 4) v++;
            pkt[0] = {4'(v), pkt[0][3:0]};
         end
         DEFECT_IHL:      pkt[0] = {ihp_pkg::IP_VERSION, 4'($urandom_range(0, 4))};
         DEFECT_RSV_FLAG: pkt[6] = pkt[6] | 8'h80;
         DEFECT_TOTAL: begin
            pkt[2] = 8'h00;
            pkt[3] = 8'($urandom_range(0, hl - 1));
         end
         DEFECT_CHECKSUM: begin
            idx      = $urandom_range(8, hl - 1);
            pkt[idx] = pkt[idx] ^ 8'(1 << $urandom_range(0, 7));
         end
         DEFECT_CUT: begin
            cut = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut) void'(pkt.pop_back());
         end
         default: begin
            pkt.delete();
            n = $urandom_range(1, 40);
            repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   task automatic send_packet();
      int i;
      for (i = 0; i < pkt.size(); i++) begin
         if (idling && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_payload <= '{data_byte: pkt[i], last_byte: (i == pkt.size() - 1)};
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      bytes_sent += pkt.size();
      packets_sent++;
   endtask

   initial begin
      int  ihl, total, extra, start_bytes, start_pkts;
      bit  hold_done;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      hold_done   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed
      make_packet(5, 20, 0, 8'h00);
      send_packet();
      make_packet(5, 20, 0, -1);
      send_packet();
      pkt = '{8'h45};
      send_packet();
      make_packet(5, 20, 0, -1);
      void'(pkt.pop_back());
      send_packet();
      make_packet(5, 28, 0, -1);
      spoil(DEFECT_VERSION);
      send_packet();
      make_packet(6, 30, 0, -1);
      pkt[0] = {ihp_pkg::IP_VERSION, 4'd0};
      send_packet();
      make_packet(5, 24, 0, -1);
      spoil(DEFECT_IHL);
      send_packet();
      make_packet(15, 60, 0, -1);
      while (pkt.size() > 30) void'(pkt.pop_back());
      send_packet();
      make_packet(5, 40, 0, -1);
      spoil(DEFECT_RSV_FLAG);
      send_packet();
      make_packet(7, 40, 0, -1);
      spoil(DEFECT_TOTAL);
      send_packet();
      make_packet(5, 40, 0, -1);
      while (pkt.size() > 30) void'(pkt.pop_back());
      send_packet();
      make_packet(6, 32, 0, -1);
      spoil(DEFECT_CHECKSUM);
      send_packet();
      make_packet(15, 60, 0, -1);
      send_packet();
      make_packet(9, 50, 7, -1);
      send_packet();
      // largest header, with all-ones fill in the fields that make_packet does not set
      make_packet(15, 64, 2, 8'hff);
      send_packet();

      // random
      start_bytes = bytes_sent;
      start_pkts  = packets_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES ||
             packets_sent - start_pkts < MIN_PACKETS) begin
         if (!hold_done && bytes_sent - start_bytes > RANDOM_BYTES / 3) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
         end
         if (bytes_sent - start_bytes > RANDOM_BYTES - QUIET_BYTES) idling = 1'b0;
         ihl   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(5, 7);
         total = 4 * ihl + $urandom_range(0, 16);
         extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
         make_packet(ihl, total, extra, -1);
         if ($urandom_range(0, 9) >= 7)
            spoil(defect_type'($urandom_range(0, DEFECT_NOISE)));
         send_packet();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d packets (%0d bytes): directed defects, random traffic, %0d-cycle hold",
               packets_sent, bytes_sent, LONG_HOLD);
      $display("Checked results: %0d ok, %0d truncated, %0d malformed; %0d mismatches",
               sb.ok_seen, sb.trunc_seen, sb.malformed_seen, sb.errors);
      if (sb.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
